@@ rtl/rhc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

  // Width of one raw sensor channel.
  localparam int CHANNEL_BITS = 10;

  // Fixed field widths.
  localparam int CFG_W  = 9;
  localparam int HUE_W  = 15;
  localparam int SAT_W  = 9;
  localparam int VAL_W  = 11;

  // One quotient bit is resolved per divider stage.
  localparam int QUO_W      = HUE_W;
  localparam int DIV_STAGES = QUO_W;
  localparam int NUM_W      = CHANNEL_BITS + QUO_W;

  // Hue numerator width: up to 360 times delta.
  localparam int HN_W = CHANNEL_BITS + 9;
  // Product width for the saturation and value cross-multiplications.
  localparam int PW   = CHANNEL_BITS + 9;

  typedef enum logic [2:0] {
    CFG_WHITE_SAT_MAX  = 3'd0,
    CFG_WHITE_VAL_MIN  = 3'd1,
    CFG_CHROMA_SAT_MIN = 3'd2,
    CFG_DARK_VAL_LIMIT = 3'd3,
    CFG_RED_SAT_MIN    = 3'd4,
    CFG_YELLOW_SAT_MIN = 3'd5
  } cfg_idx_e;

  localparam logic [CFG_W-1:0] RST_WHITE_SAT_MAX  = 9'd102;
  localparam logic [CFG_W-1:0] RST_WHITE_VAL_MIN  = 9'd179;
  localparam logic [CFG_W-1:0] RST_CHROMA_SAT_MIN = 9'd102;
  localparam logic [CFG_W-1:0] RST_DARK_VAL_LIMIT = 9'd51;
  localparam logic [CFG_W-1:0] RST_RED_SAT_MIN    = 9'd128;
  localparam logic [CFG_W-1:0] RST_YELLOW_SAT_MIN = 9'd51;

  typedef enum logic [2:0] {
    CLS_OTHER  = 3'd0,
    CLS_WHITE  = 3'd1,
    CLS_BLUE   = 3'd2,
    CLS_GREEN  = 3'd3,
    CLS_BLACK  = 3'd4,
    CLS_RED    = 3'd5,
    CLS_YELLOW = 3'd6
  } cls_e;

  // Operands of both divisions plus the fields that ride alongside them.
  typedef struct packed {
    logic [NUM_W-1:0]        hue_num;
    logic [CHANNEL_BITS-1:0] hue_den;
    logic [NUM_W-1:0]        sat_num;
    logic [CHANNEL_BITS-1:0] sat_den;
    cls_e                    cls;
    logic [VAL_W-1:0]        val;
  } div_in_t;

  // One finished result.
  typedef struct packed {
    cls_e             cls;
    logic [HUE_W-1:0] hue_q6;
    logic [SAT_W-1:0] sat_q8;
    logic [VAL_W-1:0] val_q8;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/rhc_div_pipe.sv @@
`timescale 1ns / 1ps
`default_nettype none

module rhc_div_pipe
  import rhc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    in_valid_i,
  output logic         in_ready_o,
  input  wire div_in_t in_data_i,
  output logic         out_valid_o,
  input  wire logic    out_ready_i,
  output res_t         out_data_o
);

  typedef struct packed {
    logic [CHANNEL_BITS-1:0] hrem;
    logic [QUO_W-1:0]        hlow;
    logic [QUO_W-1:0]        hquo;
    logic [CHANNEL_BITS-1:0] hden;
    logic [CHANNEL_BITS-1:0] srem;
    logic [QUO_W-1:0]        slow;
    logic [QUO_W-1:0]        squo;
    logic [CHANNEL_BITS-1:0] sden;
    cls_e                    cls;
    logic [VAL_W-1:0]        val;
  } stage_t;

  // One restoring step on both lanes. The remainder always stays below the divisor.
  function automatic stage_t div_step(stage_t s);
    logic [CHANNEL_BITS:0] ht;
    logic [CHANNEL_BITS:0] st;
    logic                  hge;
    logic                  sge;
    stage_t                n;
    n   = s;
    ht  = {s.hrem, s.hlow[QUO_W-1]};
    st  = {s.srem, s.slow[QUO_W-1]};
    hge = (ht >= {1'b0, s.hden});
    sge = (st >= {1'b0, s.sden});
    n.hrem = hge ? CHANNEL_BITS'(ht - {1'b0, s.hden}) : CHANNEL_BITS'(ht);
    n.srem = sge ? CHANNEL_BITS'(st - {1'b0, s.sden}) : CHANNEL_BITS'(st);
    n.hlow = {s.hlow[QUO_W-2:0], 1'b0};
    n.slow = {s.slow[QUO_W-2:0], 1'b0};
    n.hquo = {s.hquo[QUO_W-2:0], hge};
    n.squo = {s.squo[QUO_W-2:0], sge};
    return n;
  endfunction

  stage_t                  init;
  stage_t                  stg_q [DIV_STAGES];
  logic [DIV_STAGES-1:0]   v_q;
  logic [DIV_STAGES-1:0]   en;

  always_comb begin
    init.hrem = in_data_i.hue_num[NUM_W-1:QUO_W];
    init.hlow = in_data_i.hue_num[QUO_W-1:0];
    init.hquo = '0;
    init.hden = in_data_i.hue_den;
    init.srem = in_data_i.sat_num[NUM_W-1:QUO_W];
    init.slow = in_data_i.sat_num[QUO_W-1:0];
    init.squo = '0;
    init.sden = in_data_i.sat_den;
    init.cls  = in_data_i.cls;
    init.val  = in_data_i.val;
  end

  // A stage may load when it is empty or when the stage after it moves on.
  always_comb begin
    en[DIV_STAGES-1] = !v_q[DIV_STAGES-1] || out_ready_i;
    for (int k = DIV_STAGES - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
        if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[0] && in_valid_i) begin
      stg_q[0] <= div_step(init);
    end
    for (int k = 1; k < DIV_STAGES; k++) begin
      if (en[k] && v_q[k-1]) begin
        stg_q[k] <= div_step(stg_q[k-1]);
      end
    end
  end

  assign out_valid_o       = v_q[DIV_STAGES-1];
  assign out_data_o.cls    = stg_q[DIV_STAGES-1].cls;
  assign out_data_o.hue_q6 = stg_q[DIV_STAGES-1].hquo[HUE_W-1:0];
  assign out_data_o.sat_q8 = stg_q[DIV_STAGES-1].squo[SAT_W-1:0];
  assign out_data_o.val_q8 = stg_q[DIV_STAGES-1].val;

endmodule

`default_nettype wire

@@ rtl/rgb_hsv_color_classifier.sv @@
// Throughput: one transaction per cycle while out_ready_i does not stall the output,
// set by three front stages and a 15-stage divider that resolves one quotient bit
// of hue and saturation per stage.
// Reset (rst_ni low, asynchronous) empties every stage and loads the threshold
// registers with their default values.
`timescale 1ns / 1ps
`default_nettype none

module rgb_hsv_color_classifier
  import rhc_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  // Threshold register write port.
  input  wire logic                    cfg_we_i,
  input  wire logic [2:0]              cfg_idx_i,
  input  wire logic [CFG_W-1:0]        cfg_wdata_i,
  // Sample input channel.
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic [CHANNEL_BITS-1:0] red_raw_i,
  input  wire logic [CHANNEL_BITS-1:0] green_raw_i,
  input  wire logic [CHANNEL_BITS-1:0] blue_raw_i,
  // Result output channel.
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [2:0]                   color_class_o,
  output logic [HUE_W-1:0]             hue_q6_o,
  output logic [SAT_W-1:0]             sat_q8_o,
  output logic [VAL_W-1:0]             val_q8_o
);

  // Hue band limits in degrees and the value scale.
  localparam logic [8:0] HueBlueLo   = 9'd180;
  localparam logic [8:0] HueBlueHi   = 9'd250;
  localparam logic [8:0] HueGreenLo  = 9'd90;
  localparam logic [8:0] HueGreenHi  = 9'd155;
  localparam logic [8:0] HueRedLoLo  = 9'd0;
  localparam logic [8:0] HueRedLoHi  = 9'd30;
  localparam logic [8:0] HueRedHiLo  = 9'd330;
  localparam logic [8:0] HueRedHiHi  = 9'd360;
  localparam logic [8:0] HueYellowLo = 9'd30;
  localparam logic [8:0] HueYellowHi = 9'd80;
  localparam int         HueSector   = 60;
  localparam int         ValScale    = 255;
  // The sum for val_q8 must hold the maximum plus its 255th part.
  localparam int         VSUM_W      = (CHANNEL_BITS + 1 > VAL_W) ? CHANNEL_BITS + 1 : VAL_W;
  localparam int         RECIP_W     = CHANNEL_BITS + 10;

  typedef struct packed {
    logic sat_lo_white;
    logic sat_ok_chroma;
    logic sat_ok_red;
    logic sat_ok_yellow;
    logic val_hi_white;
    logic val_dark;
    logic hue_blue;
    logic hue_green;
    logic hue_red_lo;
    logic hue_red_hi;
    logic hue_yellow;
  } flags_t;

  // True when the hue hn/hd degrees lies within [lo, hi].
  function automatic logic hue_in(logic [HN_W-1:0] hn, logic [CHANNEL_BITS-1:0] hd,
                                  logic [8:0] lo, logic [8:0] hi);
    logic [HN_W-1:0] lo_p;
    logic [HN_W-1:0] hi_p;
    lo_p = HN_W'(hd) * HN_W'(lo);
    hi_p = HN_W'(hd) * HN_W'(hi);
    return (hn >= lo_p) && (hn <= hi_p);
  endfunction

  // True when the fraction sn/sd is below the Q8 threshold t.
  function automatic logic frac_lt(logic [CHANNEL_BITS-1:0] sn, logic [CHANNEL_BITS-1:0] sd,
                                   logic [CFG_W-1:0] t);
    logic [PW-1:0] lhs;
    logic [PW-1:0] rhs;
    lhs = PW'({sn, 8'd0});
    rhs = PW'(t) * PW'(sd);
    return lhs < rhs;
  endfunction

  // ------------------------------------------------------------------
  // Threshold registers. Writes to an index past the list are dropped.
  // ------------------------------------------------------------------
  logic [CFG_W-1:0] white_sat_max_q;
  logic [CFG_W-1:0] white_val_min_q;
  logic [CFG_W-1:0] chroma_sat_min_q;
  logic [CFG_W-1:0] dark_val_limit_q;
  logic [CFG_W-1:0] red_sat_min_q;
  logic [CFG_W-1:0] yellow_sat_min_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      white_sat_max_q  <= RST_WHITE_SAT_MAX;
      white_val_min_q  <= RST_WHITE_VAL_MIN;
      chroma_sat_min_q <= RST_CHROMA_SAT_MIN;
      dark_val_limit_q <= RST_DARK_VAL_LIMIT;
      red_sat_min_q    <= RST_RED_SAT_MIN;
      yellow_sat_min_q <= RST_YELLOW_SAT_MIN;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_WHITE_SAT_MAX:  white_sat_max_q  <= cfg_wdata_i;
        CFG_WHITE_VAL_MIN:  white_val_min_q  <= cfg_wdata_i;
        CFG_CHROMA_SAT_MIN: chroma_sat_min_q <= cfg_wdata_i;
        CFG_DARK_VAL_LIMIT: dark_val_limit_q <= cfg_wdata_i;
        CFG_RED_SAT_MIN:    red_sat_min_q    <= cfg_wdata_i;
        CFG_YELLOW_SAT_MIN: yellow_sat_min_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage handshake. Each stage loads when it is empty or when the stage
  // after it moves on, so bubbles are squeezed out and a waiting result
  // does not keep new samples from entering.
  // ------------------------------------------------------------------
  logic v1_q, v2_q, v3_q;
  logic en1, en2, en3;
  logic div_ready;

  assign en3        = !v3_q || div_ready;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: the raw sample.
  // ------------------------------------------------------------------
  logic [CHANNEL_BITS-1:0] r1_q, g1_q, b1_q;

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      r1_q <= red_raw_i;
      g1_q <= green_raw_i;
      b1_q <= blue_raw_i;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: maximum, minimum, delta and the hue as a rational hn/hd.
  // Red wins a tie for the maximum, then green.
  // ------------------------------------------------------------------
  logic [CHANNEL_BITS-1:0] mx_d, mn_d, delta_d, hd_d;
  logic [HN_W-1:0]         hn_d, hsum;
  logic [CHANNEL_BITS-1:0] mx2_q, delta2_q, hd2_q;
  logic [HN_W-1:0]         hn2_q;

  always_comb begin
    mx_d = r1_q;
    mn_d = r1_q;
    if (g1_q > mx_d) mx_d = g1_q;
    if (b1_q > mx_d) mx_d = b1_q;
    if (g1_q < mn_d) mn_d = g1_q;
    if (b1_q < mn_d) mn_d = b1_q;
    delta_d = mx_d - mn_d;

    if (mx_d == r1_q) begin
      if (g1_q >= b1_q) begin
        hsum = HN_W'(g1_q) - HN_W'(b1_q);
      end else begin
        // Wrap a negative red-sector hue up by a full turn.
        hsum = HN_W'(6) * HN_W'(delta_d) - (HN_W'(b1_q) - HN_W'(g1_q));
      end
    end else if (mx_d == g1_q) begin
      hsum = HN_W'(2) * HN_W'(delta_d) + HN_W'(b1_q) - HN_W'(r1_q);
    end else begin
      hsum = HN_W'(4) * HN_W'(delta_d) + HN_W'(r1_q) - HN_W'(g1_q);
    end

    // A gray sample has hue zero over a unit denominator.
    if (delta_d == '0) begin
      hn_d = '0;
      hd_d = CHANNEL_BITS'(1);
    end else begin
      hn_d = HN_W'(HueSector) * hsum;
      hd_d = delta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      mx2_q    <= mx_d;
      delta2_q <= delta_d;
      hn2_q    <= hn_d;
      hd2_q    <= hd_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: threshold tests by exact cross-multiplication, and val_q8.
  // max/255 is formed as ((max + 1) * 257) >> 16, exact for these 10-bit inputs.
  // ------------------------------------------------------------------
  logic [CHANNEL_BITS-1:0] sd_d;
  flags_t                  flags_d;
  logic [PW-1:0]           mx_scaled;
  logic [RECIP_W-1:0]      recip;
  logic [VSUM_W-1:0]       vsum;
  logic [VAL_W-1:0]        val_d;

  flags_t                  flags3_q;
  logic [HN_W-1:0]         hn3_q;
  logic [CHANNEL_BITS-1:0] hd3_q, delta3_q, sd3_q;
  logic [VAL_W-1:0]        val3_q;

  always_comb begin
    sd_d      = (mx2_q == '0) ? CHANNEL_BITS'(1) : mx2_q;
    mx_scaled = PW'({mx2_q, 8'd0});

    flags_d.sat_lo_white  = frac_lt(delta2_q, sd_d, white_sat_max_q);
    flags_d.sat_ok_chroma = !frac_lt(delta2_q, sd_d, chroma_sat_min_q);
    flags_d.sat_ok_red    = !frac_lt(delta2_q, sd_d, red_sat_min_q);
    flags_d.sat_ok_yellow = !frac_lt(delta2_q, sd_d, yellow_sat_min_q);
    flags_d.val_hi_white  = mx_scaled > PW'(white_val_min_q) * PW'(ValScale);
    flags_d.val_dark      = mx_scaled < PW'(dark_val_limit_q) * PW'(ValScale);
    flags_d.hue_blue      = hue_in(hn2_q, hd2_q, HueBlueLo, HueBlueHi);
    flags_d.hue_green     = hue_in(hn2_q, hd2_q, HueGreenLo, HueGreenHi);
    flags_d.hue_red_lo    = hue_in(hn2_q, hd2_q, HueRedLoLo, HueRedLoHi);
    flags_d.hue_red_hi    = hue_in(hn2_q, hd2_q, HueRedHiLo, HueRedHiHi);
    flags_d.hue_yellow    = hue_in(hn2_q, hd2_q, HueYellowLo, HueYellowHi);

    recip = (RECIP_W'(mx2_q) + RECIP_W'(1)) * RECIP_W'(257);
    vsum  = VSUM_W'(mx2_q) + VSUM_W'(recip >> 16);
    val_d = vsum[VAL_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      flags3_q <= flags_d;
      hn3_q    <= hn2_q;
      hd3_q    <= hd2_q;
      delta3_q <= delta2_q;
      sd3_q    <= sd_d;
      val3_q   <= val_d;
    end
  end

  // ------------------------------------------------------------------
  // Classification in priority order. Note the red test: the low band is
  // red at any saturation, the band below a full turn needs saturation.
  // ------------------------------------------------------------------
  cls_e    cls_d;
  div_in_t div_in;
  res_t    res;

  always_comb begin
    if (flags3_q.sat_lo_white && flags3_q.val_hi_white) begin
      cls_d = CLS_WHITE;
    end else if (flags3_q.hue_blue && flags3_q.sat_ok_chroma && !flags3_q.val_dark) begin
      cls_d = CLS_BLUE;
    end else if (flags3_q.hue_green && flags3_q.sat_ok_chroma && !flags3_q.val_dark) begin
      cls_d = CLS_GREEN;
    end else if (flags3_q.val_dark) begin
      cls_d = CLS_BLACK;
    end else if (flags3_q.hue_red_lo || (flags3_q.hue_red_hi && flags3_q.sat_ok_red)) begin
      cls_d = CLS_RED;
    end else if (flags3_q.hue_yellow && flags3_q.sat_ok_yellow) begin
      cls_d = CLS_YELLOW;
    end else begin
      cls_d = CLS_OTHER;
    end

    div_in.hue_num = {hn3_q, 6'd0};
    div_in.hue_den = hd3_q;
    div_in.sat_num = NUM_W'({delta3_q, 8'd0});
    div_in.sat_den = sd3_q;
    div_in.cls     = cls_d;
    div_in.val     = val3_q;
  end

  // ------------------------------------------------------------------
  // Divider stages: hue_q6 = hn*64/hd and sat_q8 = delta*256/max. Its
  // last stage is the output register.
  // ------------------------------------------------------------------
  rhc_div_pipe u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v3_q),
    .in_ready_o  (div_ready),
    .in_data_i   (div_in),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (res)
  );

  assign color_class_o = res.cls;
  assign hue_q6_o      = res.hue_q6;
  assign sat_q8_o      = res.sat_q8;
  assign val_q8_o      = res.val_q8;

`ifndef SYNTHESIS
  // The input side only backs up when every stage holds a transaction.
  a_ready_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled while the pipeline has room");

  // A blue result carries a hue inside the blue band.
  a_blue_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (color_class_o == CLS_BLUE)) |->
      ((hue_q6_o >= HUE_W'(11520)) && (hue_q6_o <= HUE_W'(16000))))
    else $error("blue result with hue outside its band");

  // A red result carries a hue in one of the two red bands.
  a_red_hue : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (color_class_o == CLS_RED)) |->
      ((hue_q6_o <= HUE_W'(1920)) || (hue_q6_o >= HUE_W'(21120))))
    else $error("red result with hue outside the red bands");

  // Saturation never exceeds one.
  a_sat_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sat_q8_o <= SAT_W'(256)))
    else $error("saturation above one");
`endif

endmodule

`default_nettype wire
